FILE: design/r9e5_pkg.sv
package r9e5_pkg;

    localparam logic [31:0] F32_MAX_RGB9E5 = 32'h477F8000;
    localparam logic [8:0] MANT_MAX = 9'd511;

    typedef enum logic {
        t_func_pack   = 1'b0,
        t_func_unpack = 1'b1
    } t_func;

    function automatic logic [31:0] clamp_channel(input logic [31:0] f);
        logic [31:0] r;
        r = f;
        if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
            r = F32_MAX_RGB9E5;
        end else if (f[31]) begin
            r = 32'd0;
        end else if (f > F32_MAX_RGB9E5) begin
            r = F32_MAX_RGB9E5;
        end
        return r;
    endfunction

    // The clamped channel is nonnegative and at most 65408, so its exponent
    // field is at most 142 and the shift is at least 15.
    function automatic logic [8:0] scale_channel(input logic [31:0] f, input logic [4:0] e);
        logic [7:0]  ex;
        logic [23:0] m;
        logic [8:0]  sh;
        logic [24:0] q;
        logic [47:0] ext;
        ex = f[30:23];
        m = {1'b1, f[22:0]};
        if (ex == 8'd0) begin
            ex = 8'd1;
            m = {1'b0, f[22:0]};
        end
        sh = 9'({4'd0, e}) + 9'd126 - 9'({1'b0, ex});
        ext = {m, 24'd0} >> sh[5:0];
        q = 25'({1'b0, ext[47:24]}) + 25'(ext[23]);
        if (m == 24'd0 || sh > 9'd40) begin
            return 9'd0;
        end else if (q > 25'(MANT_MAX)) begin
            return MANT_MAX;
        end
        return q[8:0];
    endfunction

    function automatic logic [31:0] decode_channel(input logic [8:0] mant, input logic [4:0] e);
        logic [3:0]  p;
        logic [22:0] frac;
        logic [7:0]  bexp;
        p = 4'd0;
        for (int i = 1; i < 9; i++) begin
            if (mant[i]) begin
                p = 4'(i);
            end
        end
        frac = 23'({mant, 23'd0} >> p);
        bexp = 8'({4'd0, p}) + 8'({3'd0, e}) + 8'd103;
        if (mant == 9'd0) begin
            return 32'd0;
        end
        return {1'b0, bexp, frac};
    endfunction

endpackage

FILE: design/rgb9e5_shared_exponent_codec.sv
// RGB9E5 shared-exponent codec.
// Input channel: i_valid from the sender with o_stall back to the sender;
// a request is taken at a rising edge with i_valid high and o_stall low.
// Each request carries i_func (0 packs, 1 unpacks), three float32 channels
// and a packed word. The result channel is o_valid with i_stall from the
// receiver; the result is taken when o_valid is high and i_stall low.
// A request is registered, converted by one stage of logic, and its result
// then loads the result register once that register is free to move.
// One request is accepted per cycle when the receiver does not stall.
// When the receiver stalls, full result and input registers hold, and
// o_stall rises once both are full, so nothing is lost.
// The synchronous active-low reset empties both registers; results on pack
// have zero float outputs, and on unpack a zero packed word.
module rgb9e5_shared_exponent_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_red_in,
    input  logic [31:0] i_green_in,
    input  logic [31:0] i_blue_in,
    input  logic [31:0] i_packed_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_packed_out,
    output logic [31:0] o_red_out,
    output logic [31:0] o_green_out,
    output logic [31:0] o_blue_out
);
    import r9e5_pkg::*;

    logic        r_in_valid;
    logic        r_func;
    logic [31:0] r_red, r_green, r_blue, r_packed;
    logic        r_out_valid;
    logic [31:0] r_packed_out, r_red_out, r_green_out, r_blue_out;
    logic [31:0] n_packed_out, n_red_out, n_green_out, n_blue_out;
    logic        out_move, in_move;
    logic [31:0] cr, cg, cb, mx;
    logic [4:0]  e;
    logic [8:0]  ue;

    assign out_move = !r_out_valid || !i_stall;
    assign in_move  = !r_in_valid || out_move;
    assign o_stall  = !in_move;

    always_comb begin
        cr = clamp_channel(r_red);
        cg = clamp_channel(r_green);
        cb = clamp_channel(r_blue);
        mx = cr;
        if (cg > mx) begin
            mx = cg;
        end
        if (cb > mx) begin
            mx = cb;
        end
        ue = 9'({1'b0, mx[30:23]}) + 9'd16;
        e = (ue > 9'd127) ? 5'(ue - 9'd127) : 5'd0;
        n_packed_out = 32'd0;
        n_red_out = 32'd0;
        n_green_out = 32'd0;
        n_blue_out = 32'd0;
        if (t_func'(r_func) == t_func_pack) begin
            n_packed_out = {e, scale_channel(cb, e), scale_channel(cg, e),
                            scale_channel(cr, e)};
        end else begin
            n_red_out   = decode_channel(r_packed[8:0], r_packed[31:27]);
            n_green_out = decode_channel(r_packed[17:9], r_packed[31:27]);
            n_blue_out  = decode_channel(r_packed[26:18], r_packed[31:27]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_move) begin
                r_in_valid <= i_valid;
            end
            if (out_move) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (in_move && i_valid) begin
            r_func   <= i_func;
            r_red    <= i_red_in;
            r_green  <= i_green_in;
            r_blue   <= i_blue_in;
            r_packed <= i_packed_in;
        end
        if (out_move && r_in_valid) begin
            r_packed_out <= n_packed_out;
            r_red_out    <= n_red_out;
            r_green_out  <= n_green_out;
            r_blue_out   <= n_blue_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_packed_out = r_packed_out;
    assign o_red_out    = r_red_out;
    assign o_green_out  = r_green_out;
    assign o_blue_out   = r_blue_out;

endmodule

FILE: design/r9e5_checker.sv
module r9e5_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_packed_out,
    input logic [31:0] o_red_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packed_out))
        else $error("Stalled result changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Reset did not empty the block.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("Input stalled while output could move.");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_stall |=> ##1 o_valid)
        else $error("Accepted request produced no result.");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_packed_out == 32'd0 || o_red_out == 32'd0)
        else $error("Both result kinds nonzero.");

endmodule

bind rgb9e5_shared_exponent_codec r9e5_checker u_r9e5_checker (.*);
